/* sv/adsr_pkg.sv */
// Shared types, step tables and constants for the ADSR envelope generator.
package adsr_pkg;

   localparam int TICK_MS  = 20;
   localparam int AMAX     = 31 * 256;
   localparam int ASTEP    = AMAX * TICK_MS / 4;
   localparam int SUS_UNIT = AMAX / 16;

   localparam int LEVEL_W = 13;
   localparam int CODE_W  = 4;
   localparam int STEP_W  = $clog2(ASTEP / 2 + 1);
   localparam int SUM_W   = STEP_W + 1;

   typedef enum logic [1:0] {
      PH_RELEASE = 2'd0,
      PH_OFF     = 2'd1,
      PH_ATTACK  = 2'd2,
      PH_DECAY   = 2'd3
   } adsr_phase_type;

   typedef struct packed {
      logic              gate;
      logic [CODE_W-1:0] attack_code;
      logic [CODE_W-1:0] decay_code;
      logic [CODE_W-1:0] sustain_code;
      logic [CODE_W-1:0] release_code;
   } adsr_req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [1:0]         phase_now;
   } adsr_rsp_type;

   typedef struct packed {
      adsr_phase_type     phase;
      logic [LEVEL_W-1:0] level;
   } adsr_state_type;

   localparam logic [STEP_W-1:0] ATK_TAB [16] = '{
      STEP_W'(ASTEP / 2),    STEP_W'(ASTEP / 8),    STEP_W'(ASTEP / 16),
      STEP_W'(ASTEP / 24),   STEP_W'(ASTEP / 38),   STEP_W'(ASTEP / 56),
      STEP_W'(ASTEP / 68),   STEP_W'(ASTEP / 80),   STEP_W'(ASTEP / 100),
      STEP_W'(ASTEP / 250),  STEP_W'(ASTEP / 500),  STEP_W'(ASTEP / 800),
      STEP_W'(ASTEP / 1000), STEP_W'(ASTEP / 3000), STEP_W'(ASTEP / 5000),
      STEP_W'(ASTEP / 8000)
   };

   localparam logic [STEP_W-1:0] DEC_TAB [16] = '{
      STEP_W'(ASTEP / 6),     STEP_W'(ASTEP / 24),    STEP_W'(ASTEP / 48),
      STEP_W'(ASTEP / 72),    STEP_W'(ASTEP / 114),   STEP_W'(ASTEP / 168),
      STEP_W'(ASTEP / 204),   STEP_W'(ASTEP / 240),   STEP_W'(ASTEP / 300),
      STEP_W'(ASTEP / 750),   STEP_W'(ASTEP / 1500),  STEP_W'(ASTEP / 2400),
      STEP_W'(ASTEP / 3000),  STEP_W'(ASTEP / 9000),  STEP_W'(ASTEP / 15000),
      STEP_W'(ASTEP / 24000)
   };

endpackage

/* sv/adsr_envelope_generator.sv */
// ADSR envelope generator top level: input register, envelope state, result register.
// A request is held in the input register and its result is registered in the result register.
// Throughput: one tick per cycle unless stalled; state updates as a tick leaves the input register.
// Both stages hold under backpressure, and a new request is taken while a result waits.
// Reset: synchronous, active high; phase off, level 0, both stages empty.
module adsr_envelope_generator (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  adsr_pkg::adsr_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output adsr_pkg::adsr_rsp_type rsp_data
);
   import adsr_pkg::*;

   adsr_req_type   req_ff;
   logic           req_valid_ff;
   adsr_state_type state_ff;
   adsr_state_type state_in;
   adsr_rsp_type   rsp_ff;
   logic           rsp_valid_ff;
   logic           advance;

   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   adsr_step u_step (
      .req (req_ff),
      .cur (state_ff),
      .nxt (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         state_ff.phase <= PH_OFF;
         state_ff.level <= '0;
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff.level     <= state_in.level;
         rsp_ff.phase_now <= 2'(state_in.phase);
      end
   end

endmodule

/* sv/adsr_step.sv */
// Next-state logic for one envelope tick: gate handling then one phase step.
module adsr_step (
   input  adsr_pkg::adsr_req_type   req,
   input  adsr_pkg::adsr_state_type cur,
   output adsr_pkg::adsr_state_type nxt
);
   import adsr_pkg::*;

   always_comb begin
      adsr_phase_type     ph;
      logic [LEVEL_W-1:0] lv;
      logic [STEP_W-1:0]  step;
      logic [LEVEL_W-1:0] sus;
      logic [SUM_W-1:0]   sum;
      logic [SUM_W-1:0]   lim;

      ph   = cur.phase;
      lv   = cur.level;
      step = '0;
      sus  = LEVEL_W'(int'(req.sustain_code) * SUS_UNIT);
      sum  = '0;
      lim  = '0;

      if (req.gate) begin
         if (ph == PH_RELEASE || ph == PH_OFF) begin
            ph = PH_ATTACK;
            lv = '0;
         end
      end else if (ph == PH_ATTACK || ph == PH_DECAY) begin
         ph = PH_RELEASE;
      end

      case (ph)
         PH_ATTACK: begin
            step = ATK_TAB[req.attack_code];
            sum  = SUM_W'(lv) + SUM_W'(step);
            if (sum >= SUM_W'(AMAX)) begin
               lv = LEVEL_W'(AMAX);
               ph = PH_DECAY;
            end else begin
               lv = sum[LEVEL_W-1:0];
            end
         end
         PH_DECAY: begin
            step = DEC_TAB[req.decay_code];
            lim  = SUM_W'(sus) + SUM_W'(step);
            if (SUM_W'(lv) > lim) begin
               lv = lv - step[LEVEL_W-1:0];
            end else if (lv > sus) begin
               lv = sus;
            end
         end
         PH_RELEASE: begin
            step = DEC_TAB[req.release_code];
            if (SUM_W'(lv) > SUM_W'(step)) begin
               lv = lv - step[LEVEL_W-1:0];
            end else begin
               lv = '0;
               ph = PH_OFF;
            end
         end
         default: begin
            lv = lv;
         end
      endcase

      nxt.phase = ph;
      nxt.level = lv;
   end

endmodule

/* test/tb_adsr_envelope_generator.sv */
// Self-checking testbench for the ADSR envelope generator: directed table, random notes, idle mixes.
module tb_adsr_envelope_generator;
   timeunit 1ns;
   timeprecision 1ps;

   import adsr_pkg::*;

   localparam int RANDOM_TICKS = 1120;
   localparam int SETTLE_CYCLES = 8;
   localparam int FULL_LEVEL = AMAX;
   localparam int ATTACK_DIV [16] = '{2, 8, 16, 24, 38, 56, 68, 80,
                                      100, 250, 500, 800, 1000, 3000, 5000, 8000};
   localparam int FALL_DIV [16] = '{6, 24, 48, 72, 114, 168, 204, 240,
                                    300, 750, 1500, 2400, 3000, 9000, 15000, 24000};

   typedef struct {
      adsr_req_type   tick;
      bit             typed;
      int             lvl;
      adsr_phase_type ph;
   } directed_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   adsr_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   adsr_rsp_type rsp_data;

   adsr_phase_type   env_phase;
   logic [12:0]      env_level;
   adsr_rsp_type     level_phase_q [$];
   directed_row_type directed_rows [$];
   int               send_idle_pct = 0;
   int               stall_pct = 0;
   int               error_count = 0;
   int               ticks_sent = 0;
   int               results_seen = 0;
   int               phase_hits [4] = '{0, 0, 0, 0};

   adsr_envelope_generator u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #6ns clock = 1'b1;
      #6ns clock = 1'b0;
   end

   initial begin
      #3ms;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic adsr_rsp_type advance_envelope(input adsr_req_type tick);
      int lvl;
      int sus;
      int stp;
      adsr_rsp_type res;
      lvl = int'(env_level);
      if (tick.gate) begin
         if (env_phase == PH_RELEASE || env_phase == PH_OFF) begin
            env_phase = PH_ATTACK;
            lvl = 0;
         end
      end else if (env_phase == PH_ATTACK || env_phase == PH_DECAY) begin
         env_phase = PH_RELEASE;
      end
      case (env_phase)
         PH_ATTACK: begin
            lvl = lvl + ASTEP / ATTACK_DIV[tick.attack_code];
            if (lvl >= FULL_LEVEL) begin
               lvl = FULL_LEVEL;
               env_phase = PH_DECAY;
            end
         end
         PH_DECAY: begin
            sus = SUS_UNIT * int'(tick.sustain_code);
            stp = ASTEP / FALL_DIV[tick.decay_code];
            if (lvl > sus + stp) begin
               lvl = lvl - stp;
            end else if (lvl > sus) begin
               lvl = sus;
            end
         end
         PH_RELEASE: begin
            stp = ASTEP / FALL_DIV[tick.release_code];
            if (lvl > stp) begin
               lvl = lvl - stp;
            end else begin
               lvl = 0;
               env_phase = PH_OFF;
            end
         end
         default: begin
         end
      endcase
      env_level = lvl[12:0];
      res.level = env_level;
      res.phase_now = env_phase;
      return res;
   endfunction

   task automatic add_row(input bit g, input int a, input int d, input int s, input int r,
                          input bit typed, input int lvl, input adsr_phase_type ph);
      directed_row_type row;
      row.tick.gate = g;
      row.tick.attack_code = a[3:0];
      row.tick.decay_code = d[3:0];
      row.tick.sustain_code = s[3:0];
      row.tick.release_code = r[3:0];
      row.typed = typed;
      row.lvl = lvl;
      row.ph = ph;
      directed_rows.push_back(row);
   endtask

   // hold the tick until transfer, then queue what the envelope should show
   task automatic send_tick(input adsr_req_type tick, input bit typed, input int lvl,
                            input adsr_phase_type ph);
      adsr_rsp_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= tick;
      do @(posedge clock); while (!req_ready);
      predicted = advance_envelope(tick);
      if (typed) begin
         predicted.level = lvl[12:0];
         predicted.phase_now = ph;
      end
      level_phase_q.push_back(predicted);
      ticks_sent++;
   endtask

   task automatic play_notes(input int count);
      adsr_req_type tick;
      int sent;
      int hold_len;
      int rest_len;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 99) < 15) begin
            tick = adsr_req_type'($urandom());
            send_tick(tick, 1'b0, 0, PH_OFF);
            sent++;
         end else begin
            tick.attack_code = 4'(($urandom_range(0, 99) < 60) ? $urandom_range(0, 8)
                                                                 : $urandom_range(0, 15));
            tick.decay_code = 4'($urandom_range(0, 15));
            tick.sustain_code = 4'($urandom_range(0, 15));
            tick.release_code = 4'(($urandom_range(0, 99) < 60) ? $urandom_range(0, 6)
                                                                  : $urandom_range(0, 15));
            hold_len = $urandom_range(1, 30);
            rest_len = $urandom_range(1, 25);
            tick.gate = 1'b1;
            for (int i = 0; i < hold_len && sent < count; i++) begin
               if ($urandom_range(0, 99) < 10) begin
                  tick.sustain_code = 4'($urandom_range(0, 15));
               end
               if ($urandom_range(0, 99) < 10) begin
                  tick.decay_code = 4'($urandom_range(0, 15));
               end
               send_tick(tick, 1'b0, 0, PH_OFF);
               sent++;
            end
            tick.gate = 1'b0;
            for (int i = 0; i < rest_len && sent < count; i++) begin
               send_tick(tick, 1'b0, 0, PH_OFF);
               sent++;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      adsr_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (level_phase_q.size() == 0) begin
            $error("unexpected result: level %0d phase %0d", rsp_data.level,
                   rsp_data.phase_now);
            error_count++;
         end else begin
            want = level_phase_q.pop_front();
            phase_hits[want.phase_now]++;
            if (rsp_data.level !== want.level) begin
               $error("level: expected %0d, got %0d", want.level, rsp_data.level);
               error_count++;
            end
            if (rsp_data.phase_now !== want.phase_now) begin
               $error("phase_now: expected %0d, got %0d", want.phase_now,
                      rsp_data.phase_now);
               error_count++;
            end
         end
      end
   end

   initial begin
      env_phase = PH_OFF;
      env_level = '0;

      add_row(0, 0, 0, 0, 0, 1, 0, PH_OFF);
      add_row(0, 15, 15, 15, 15, 1, 0, PH_OFF);
      add_row(1, 0, 15, 15, 15, 1, FULL_LEVEL, PH_DECAY);
      add_row(1, 0, 0, 15, 15, 0, 0, PH_OFF);
      add_row(1, 0, 0, 15, 15, 0, 0, PH_OFF);
      add_row(1, 0, 0, 0, 15, 0, 0, PH_OFF);
      add_row(1, 0, 0, 0, 15, 0, 0, PH_OFF);
      add_row(1, 0, 0, 0, 15, 0, 0, PH_OFF);
      add_row(1, 0, 0, 5, 15, 0, 0, PH_OFF);
      add_row(0, 0, 0, 0, 0, 1, 0, PH_OFF);
      add_row(0, 15, 15, 15, 15, 1, 0, PH_OFF);
      add_row(1, 15, 0, 0, 0, 0, 0, PH_OFF);
      add_row(1, 15, 0, 0, 0, 0, 0, PH_OFF);
      add_row(0, 15, 15, 15, 15, 0, 0, PH_OFF);
      add_row(0, 15, 15, 15, 15, 0, 0, PH_OFF);
      add_row(1, 0, 15, 0, 15, 1, FULL_LEVEL, PH_DECAY);
      add_row(0, 0, 0, 0, 0, 0, 0, PH_OFF);
      add_row(0, 0, 0, 0, 0, 0, 0, PH_OFF);
      add_row(1, 1, 0, 0, 0, 0, 0, PH_OFF);
      add_row(0, 1, 0, 0, 8, 0, 0, PH_OFF);
      add_row(1, 1, 0, 0, 8, 0, 0, PH_OFF);
      add_row(1, 1, 15, 0, 8, 0, 0, PH_OFF);
      add_row(1, 1, 15, 0, 8, 0, 0, PH_OFF);
      add_row(1, 0, 0, 15, 0, 0, 0, PH_OFF);
      add_row(0, 0, 0, 15, 10, 0, 0, PH_OFF);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int mix = 0; mix < 4; mix++) begin
         case (mix)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 74;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 74;
            end
            default: begin
               send_idle_pct = 28;
               stall_pct = 28;
            end
         endcase
         if (mix == 0) begin
            foreach (directed_rows[i]) begin
               send_tick(directed_rows[i].tick, directed_rows[i].typed, directed_rows[i].lvl,
                         directed_rows[i].ph);
            end
         end
         play_notes(RANDOM_TICKS / 4);
         // drain before changing the idle mix
         req_valid <= 1'b0;
         while (level_phase_q.size() != 0) @(posedge clock);
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (level_phase_q.size() != 0) begin
         $error("%0d expected results never arrived", level_phase_q.size());
         error_count++;
      end
      $display("Sent %0d ticks (directed table plus random notes) under four idle/stall mixes.",
               ticks_sent);
      $display("Checked %0d results: release %0d, off %0d, attack %0d, decay %0d.",
               results_seen, phase_hits[PH_RELEASE], phase_hits[PH_OFF],
               phase_hits[PH_ATTACK], phase_hits[PH_DECAY]);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/adsr_pkg.sv
sv/adsr_step.sv
sv/adsr_envelope_generator.sv
test/tb_adsr_envelope_generator.sv
